// ===== sv/activity_break_reminder_timer_core_assert.svh =====
// Assertion macros for the activity break reminder timer.
// Expects clk and rst to be visible where a macro is used.
`ifndef ACTIVITY_BREAK_REMINDER_TIMER_CORE_ASSERT_SVH
`define ACTIVITY_BREAK_REMINDER_TIMER_CORE_ASSERT_SVH

// Checks an implication, clocked on clk and switched off during reset.
`define ABRT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checks an implication that must also hold while reset is high.
`define ABRT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/abrt_pkg.sv =====
// Package for the activity break reminder timer.
// Holds widths, command, mode and event codes, and configuration defaults.
package abrt_pkg;

  localparam int TimeWidth = 32;
  localparam int FuncWidth = 3;
  localparam int CodeWidth = 2;
  localparam int CfgIdxWidth = 2;

  typedef logic [TimeWidth-1:0] time_t;
  typedef logic [FuncWidth-1:0] func_t;
  typedef logic [CodeWidth-1:0] code_t;
  typedef logic [CfgIdxWidth-1:0] cfg_idx_t;

  localparam func_t FUNC_TICK   = 3'd0;
  localparam func_t FUNC_PAUSE  = 3'd1;
  localparam func_t FUNC_RESET  = 3'd2;
  localparam func_t FUNC_SNOOZE = 3'd3;
  localparam func_t FUNC_REST   = 3'd4;

  localparam code_t MODE_WORK  = 2'd0;
  localparam code_t MODE_PAUSE = 2'd1;
  localparam code_t MODE_REST  = 2'd2;

  localparam code_t EV_NONE       = 2'd0;
  localparam code_t EV_REST_DONE  = 2'd1;
  localparam code_t EV_IDLE_RESET = 2'd2;
  localparam code_t EV_REMIND     = 2'd3;

  localparam cfg_idx_t CFG_WORK_INTERVAL  = 2'd0;
  localparam cfg_idx_t CFG_IDLE_THRESHOLD = 2'd1;
  localparam cfg_idx_t CFG_REST_DURATION  = 2'd2;
  localparam cfg_idx_t CFG_IDLE_RESET     = 2'd3;

  localparam time_t WORK_INTERVAL_RST  = time_t'(1200000);
  localparam time_t IDLE_THRESHOLD_RST = time_t'(60000);
  localparam time_t REST_DURATION_RST  = time_t'(20000);
  localparam time_t IDLE_RESET_RST     = time_t'(300000);

  localparam time_t TIME_ONE  = time_t'(1);
  localparam time_t TIME_ZERO = time_t'(0);

  function automatic time_t sub_floor(time_t a, time_t b);
    return (b >= a) ? TIME_ZERO : a - b;
  endfunction

endpackage

// ===== sv/abrt_if.sv =====
// Request and result channel interfaces of the activity break reminder timer.
// Depends on abrt_pkg for the payload types.
interface abrt_cmd_if;
  import abrt_pkg::*;
  logic  valid;
  logic  ready;
  func_t func;
  time_t elapsed;
  time_t idle_time;
  time_t snooze_length;
  modport source (output valid, func, elapsed, idle_time, snooze_length, input ready);
  modport sink (input valid, func, elapsed, idle_time, snooze_length, output ready);
endinterface

interface abrt_res_if;
  import abrt_pkg::*;
  logic  valid;
  logic  ready;
  code_t event_res;
  code_t mode;
  time_t active_total;
  time_t work_left;
  time_t rest_left;
  time_t snooze_left;
  logic  snoozing;
  logic  usage_active;
  modport source (output valid, event_res, mode, active_total, work_left, rest_left,
                  snooze_left, snoozing, usage_active, input ready);
  modport sink (input valid, event_res, mode, active_total, work_left, rest_left,
                snooze_left, snoozing, usage_active, output ready);
endinterface

// ===== sv/activity_break_reminder_timer_core.sv =====
// Top level of the activity break reminder timer.
// Depends on abrt_pkg, abrt_if.sv and activity_break_reminder_timer_core_assert.svh.

// Each request is one command and yields exactly one result in the next cycle. The
// whole command is evaluated combinationally between the request handshake and
// the result register, so a new request is taken every cycle as long as the
// result register is empty or its result is taken in the same cycle. Configuration
// writes are registered and apply to the next request.
`include "activity_break_reminder_timer_core_assert.svh"

module activity_break_reminder_timer_core (
  input  logic                clk,
  input  logic                rst,
  abrt_cmd_if.sink            cmd,
  abrt_res_if.source          res,
  input  logic                cfg_we,
  input  abrt_pkg::cfg_idx_t  cfg_index,
  input  abrt_pkg::time_t     cfg_data
);
  import abrt_pkg::*;

  time_t work_span;
  time_t away_level;
  time_t break_len;
  time_t clear_level;

  code_t run_mode;
  time_t active_accum;
  time_t rest_countdown;
  time_t snooze_countdown;
  logic  reminder_done;
  logic  idle_clear_done;

  code_t run_mode_next;
  time_t active_accum_next;
  time_t rest_countdown_next;
  time_t snooze_countdown_next;
  logic  reminder_done_next;
  logic  idle_clear_done_next;
  code_t event_next;

  time_t eff_work;
  time_t eff_rest;
  time_t eff_idle_reset;
  time_t rest_sub;
  time_t snooze_sub;
  time_t accum_sum;
  logic  accum_sat;
  logic  accept;

  assign accept = cmd.valid && cmd.ready;
  assign cmd.ready = !res.valid || res.ready;

  assign eff_work = (work_span < TIME_ONE) ? TIME_ONE : work_span;
  assign eff_rest = (break_len < TIME_ONE) ? TIME_ONE : break_len;
  assign eff_idle_reset = (clear_level < away_level) ? away_level : clear_level;
  assign rest_sub = sub_floor(rest_countdown, cmd.elapsed);
  assign snooze_sub = sub_floor(snooze_countdown, cmd.elapsed);
  assign accum_sat = (active_accum >= eff_work) ||
                     (cmd.elapsed >= eff_work - active_accum);
  assign accum_sum = active_accum + cmd.elapsed;

  always_comb begin
    run_mode_next = run_mode;
    active_accum_next = active_accum;
    rest_countdown_next = rest_countdown;
    snooze_countdown_next = snooze_countdown;
    reminder_done_next = reminder_done;
    idle_clear_done_next = idle_clear_done;
    event_next = EV_NONE;
    case (cmd.func)
      FUNC_TICK: begin
        if (run_mode == MODE_REST) begin
          rest_countdown_next = rest_sub;
          if (rest_sub == TIME_ZERO) begin
            run_mode_next = MODE_WORK;
            active_accum_next = TIME_ZERO;
            rest_countdown_next = TIME_ZERO;
            snooze_countdown_next = TIME_ZERO;
            reminder_done_next = 1'b0;
            idle_clear_done_next = 1'b0;
            event_next = EV_REST_DONE;
          end
        end else if (cmd.idle_time >= eff_idle_reset) begin
          if (!idle_clear_done) begin
            active_accum_next = TIME_ZERO;
            snooze_countdown_next = TIME_ZERO;
            reminder_done_next = 1'b0;
            idle_clear_done_next = 1'b1;
            event_next = EV_IDLE_RESET;
          end
        end else begin
          idle_clear_done_next = 1'b0;
          if (run_mode == MODE_PAUSE) begin
            event_next = EV_NONE;
          end else if (snooze_countdown != TIME_ZERO) begin
            snooze_countdown_next = snooze_sub;
            if (snooze_sub == TIME_ZERO) begin
              reminder_done_next = 1'b1;
              event_next = EV_REMIND;
            end
          end else begin
            if (cmd.idle_time < away_level) begin
              active_accum_next = accum_sat ? eff_work : accum_sum;
            end
            if ((active_accum_next >= eff_work) && !reminder_done) begin
              reminder_done_next = 1'b1;
              event_next = EV_REMIND;
            end
          end
        end
      end
      FUNC_PAUSE: begin
        if (run_mode != MODE_REST) begin
          run_mode_next = (run_mode == MODE_PAUSE) ? MODE_WORK : MODE_PAUSE;
        end
      end
      FUNC_RESET: begin
        run_mode_next = MODE_WORK;
        active_accum_next = TIME_ZERO;
        rest_countdown_next = TIME_ZERO;
        snooze_countdown_next = TIME_ZERO;
        reminder_done_next = 1'b0;
        idle_clear_done_next = 1'b0;
      end
      FUNC_SNOOZE: begin
        run_mode_next = MODE_WORK;
        snooze_countdown_next = (cmd.snooze_length < TIME_ONE) ? TIME_ONE
                                                               : cmd.snooze_length;
        reminder_done_next = 1'b0;
      end
      FUNC_REST: begin
        run_mode_next = MODE_REST;
        rest_countdown_next = eff_rest;
        snooze_countdown_next = TIME_ZERO;
        reminder_done_next = 1'b0;
      end
      default: begin
        event_next = EV_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      work_span <= WORK_INTERVAL_RST;
      away_level <= IDLE_THRESHOLD_RST;
      break_len <= REST_DURATION_RST;
      clear_level <= IDLE_RESET_RST;
      run_mode <= MODE_WORK;
      active_accum <= TIME_ZERO;
      rest_countdown <= TIME_ZERO;
      snooze_countdown <= TIME_ZERO;
      reminder_done <= 1'b0;
      idle_clear_done <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_WORK_INTERVAL:  work_span <= cfg_data;
          CFG_IDLE_THRESHOLD: away_level <= cfg_data;
          CFG_REST_DURATION:  break_len <= cfg_data;
          CFG_IDLE_RESET:     clear_level <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        run_mode <= run_mode_next;
        active_accum <= active_accum_next;
        rest_countdown <= rest_countdown_next;
        snooze_countdown <= snooze_countdown_next;
        reminder_done <= reminder_done_next;
        idle_clear_done <= idle_clear_done_next;
        res.valid <= 1'b1;
        res.event_res <= event_next;
        res.mode <= run_mode_next;
        res.active_total <= active_accum_next;
        res.work_left <= sub_floor(eff_work, active_accum_next);
        res.rest_left <= rest_countdown_next;
        res.snooze_left <= snooze_countdown_next;
        res.snoozing <= (snooze_countdown_next != TIME_ZERO);
        res.usage_active <= (run_mode_next == MODE_WORK) &&
                            (cmd.idle_time < away_level);
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  `ABRT_ASSERT(a_result_follows, (cmd.valid && cmd.ready) |=> res.valid, "request lost")
  `ABRT_ASSERT(a_rest_no_snooze,
    (res.valid && res.mode == MODE_REST) |-> (res.snooze_left == TIME_ZERO && !res.snoozing),
    "snooze active while resting")
  `ABRT_ASSERT(a_rest_done_clear,
    (res.valid && res.event_res == EV_REST_DONE) |->
      (res.mode == MODE_WORK && res.active_total == TIME_ZERO && res.rest_left == TIME_ZERO),
    "rest finished without full clear")
  `ABRT_ASSERT_ALWAYS(a_reset_empty, rst |=> !res.valid, "result pending after reset")

endmodule
